// File: src/kecrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kecrb_pkg
// Shared types and constants for the key event character queue.
// ----------------------------------------------------------------------------
package kecrb_pkg;

   localparam int CHAR_W = 8;
   localparam int FILL_W = 4;

   // request kinds
   localparam logic REQ_KEY = 1'b0;
   localparam logic REQ_POP = 1'b1;

   localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'd32;
   localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'd126;
   localparam logic [CHAR_W-1:0] EMPTY_CODE = 8'hFF;

   typedef struct packed {
      logic              req_type;
      logic              key_down;
      logic [CHAR_W-1:0] key_ascii;
      logic [CHAR_W-1:0] key_mods;
   } kecrb_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] pop_char;
      logic              pop_valid;
      logic [FILL_W-1:0] fill_count;
   } kecrb_rsp_type;

   // status of a finished pop, from the controller to the top level
   typedef struct packed {
      logic              strobe;
      logic              valid;
      logic [FILL_W-1:0] fill;
   } kecrb_pop_stat_type;

endpackage

// File: src/kecrb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kecrb_store
// Character memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kecrb_store #(
   parameter int QUEUE_DEPTH = 8,
   parameter int IDX_W       = 3
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [kecrb_pkg::CHAR_W-1:0] wr_data,
   input  logic [IDX_W-1:0]             rd_addr,
   output logic [kecrb_pkg::CHAR_W-1:0] rd_data
);
   import kecrb_pkg::*;

   logic [CHAR_W-1:0] mem [QUEUE_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/kecrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kecrb_ctrl
// Request register, append rules, ring pointers and held count.
// ----------------------------------------------------------------------------
module kecrb_ctrl #(
   parameter int QUEUE_DEPTH = 8,
   parameter int IDX_W       = 3,
   parameter int CNT_W       = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  kecrb_pkg::kecrb_req_type      req_data,
   output logic                          busy,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [kecrb_pkg::CHAR_W-1:0]  wr_data,
   output logic [IDX_W-1:0]              rd_addr,
   output kecrb_pkg::kecrb_pop_stat_type pop_stat
);
   import kecrb_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic               in_vld_ff;
   kecrb_req_type      req_ff;
   logic               pend_ff, pend_in;
   logic [CHAR_W-1:0]  pend_code_ff;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   kecrb_pop_stat_type stat_ff, stat_in;

   logic is_key, is_pop, rule_print, rule_mods, push_now, twice;

   always_comb begin
      is_key     = in_vld_ff && (req_ff.req_type == REQ_KEY) && req_ff.key_down;
      is_pop     = in_vld_ff && (req_ff.req_type == REQ_POP);
      rule_print = req_ff.key_ascii inside {[PRINT_LOW:PRINT_HIGH]};
      rule_mods  = (req_ff.key_mods != '0) && (req_ff.key_ascii != '0);
      twice      = is_key && rule_print && rule_mods;
      // the second copy of a doubled key goes in the following cycle
      push_now   = pend_ff || (is_key && (rule_print || rule_mods));
      pend_in    = twice;

      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      cnt_in    = cnt_ff;

      if (push_now) begin
         wr_idx_in = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
         if (cnt_ff == FULL_CNT) begin
            // full: the oldest entry is dropped
            rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (is_pop && (cnt_ff != '0)) begin
         rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
         cnt_in    = cnt_ff - 1'b1;
      end

      stat_in.strobe = is_pop;
      stat_in.valid  = (cnt_ff != '0);
      stat_in.fill   = FILL_W'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         cnt_ff        <= '0;
         stat_ff       <= '0;
      end else begin
         in_vld_ff     <= start && !busy;
         pend_ff       <= pend_in;
         rd_idx_ff     <= rd_idx_in;
         wr_idx_ff     <= wr_idx_in;
         cnt_ff        <= cnt_in;
         stat_ff       <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      if (twice) begin
         pend_code_ff <= req_ff.key_ascii;
      end
   end

   assign busy     = twice;
   assign wr_en    = push_now;
   assign wr_addr  = wr_idx_ff;
   assign wr_data  = pend_ff ? pend_code_ff : req_ff.key_ascii;
   assign rd_addr  = rd_idx_ff;
   assign pop_stat = stat_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT)
      else $error("held count above queue depth");

   a_pend_follows: assert property (@(posedge clock) disable iff (reset)
      twice |=> pend_ff)
      else $error("second copy of doubled key not scheduled");

   a_pend_alone: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !in_vld_ff)
      else $error("request entered while second copy pending");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (stat_ff.strobe && !stat_ff.valid) |-> (cnt_ff == '0))
      else $error("failed pop with characters held");
`endif

endmodule

// File: src/key_event_char_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_char_ring_buffer
// Keyboard character queue that overwrites the oldest entry when full.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one request per
// cycle is accepted while busy is low. A pop answers with rsp_strobe high
// for one cycle, after the request and status registers, and the receiver
// cannot stall it. A key press that both rules append (printable with
// modifiers held) writes two entries through the single memory write port,
// so busy is high for one cycle and the second entry follows. Key events
// return no response. No clearing pass is needed after reset.
module key_event_char_ring_buffer #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  kecrb_pkg::kecrb_req_type req_data,
   output logic                     rsp_strobe,
   output kecrb_pkg::kecrb_rsp_type rsp_data
);
   import kecrb_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [CHAR_W-1:0]  wr_data, rd_data;
   kecrb_pop_stat_type pop_stat;

   kecrb_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .pop_stat (pop_stat)
   );

   kecrb_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // empty queue answers with the marker code
   always_comb begin
      rsp_strobe          = pop_stat.strobe;
      rsp_data.pop_char   = pop_stat.valid ? rd_data : EMPTY_CODE;
      rsp_data.pop_valid  = pop_stat.valid;
      rsp_data.fill_count = pop_stat.fill;
   end

endmodule
